/* rtl/core/sfr_pkg.sv */
// shared constants and register codes for the stream find-and-replace block
package sfr_pkg;

  localparam int BYTE_W          = 8;
  localparam int REG_W           = 64;
  localparam int LEN_W           = 4;
  localparam int MAX_PATTERN_DEF = 8;
  localparam int MAX_RESULTS     = 8;
  localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int RES_IDX_W       = $clog2(MAX_RESULTS);
  localparam int CFG_IDX_W       = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES      = 2'd0,
    REG_PATTERN_LENGTH     = 2'd1,
    REG_REPLACEMENT_BYTES  = 2'd2,
    REG_REPLACEMENT_LENGTH = 2'd3
  } cfg_reg_t;

endpackage

/* rtl/core/sfr_if.sv */
// handshake interfaces for text input, rewritten output and configuration
interface sfr_in_if;
  logic                      valid;
  logic                      ready;
  logic [sfr_pkg::BYTE_W-1:0] text_byte;
  logic                      final_byte;
  modport source (output valid, text_byte, final_byte, input ready);
  modport sink   (input valid, text_byte, final_byte, output ready);
endinterface

interface sfr_out_if;
  logic                      valid;
  logic                      ready;
  logic [sfr_pkg::BYTE_W-1:0] out_byte;
  logic                      out_valid;
  logic                      out_last;
  modport source (output valid, out_byte, out_valid, out_last, input ready);
  modport sink   (input valid, out_byte, out_valid, out_last, output ready);
endinterface

interface sfr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sfr_pkg::CFG_IDX_W-1:0] index;
  logic [sfr_pkg::REG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/stream_find_and_replace_top.sv */
// stream find-and-replace: window compare, result buffer and output register
//
// Usage:
//   text_in carries one text word per handshake (text_byte, final_byte).
//   text_out carries one result word per handshake (out_byte, out_valid,
//   out_last). cfg writes pattern bytes/length and replacement bytes/length
//   by register index; writes are taken whenever rst is low and must only be
//   made while the block is idle. Writing the pattern length drops the window.
//   Each accepted word is compared against the pattern combinationally and its
//   results (0 to 8) land in a result buffer; while text_out does not stall
//   they leave one per cycle from the buffer through an output register.
//   Throughput: one text word per cycle while each word yields at most one
//   result and text_out keeps up; else text_in waits for a word's last result.
//   When text_out stalls, the output register holds its word, the buffer
//   takes the results of one more text word and text_in then waits.
//   Reset (rst, synchronous) empties the window, the buffer and the output
//   register and restores the register defaults (pattern length 1,
//   replacement length 0). A final word with nothing to emit yields one
//   word with out_valid low and out_last high.
module stream_find_and_replace_top #(
  parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF
) (
  input  logic      clk,
  input  logic      rst,
  sfr_in_if.sink    text_in,
  sfr_out_if.source text_out,
  sfr_cfg_if.sink   cfg
);
  import sfr_pkg::*;

  localparam int CNT_W = $clog2(MAX_PATTERN + 1);

  // configuration registers
  logic [REG_W-1:0] pattern_bytes;
  logic [LEN_W-1:0] pattern_length;
  logic [REG_W-1:0] replacement_bytes;
  logic [LEN_W-1:0] replacement_length;

  // window
  logic [BYTE_W-1:0] window_store [MAX_PATTERN];
  logic [CNT_W-1:0]  window_count;

  // result buffer
  logic [REG_W-1:0]     pend_bytes;
  logic [RES_CNT_W-1:0] pend_rem;
  logic [RES_IDX_W-1:0] pend_idx;
  logic                 pend_void;
  logic                 pend_last;

  // output register
  logic              out_full;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_valid_r;
  logic              out_last_r;

  // datapath signals
  logic [CNT_W-1:0]     plen;
  logic [LEN_W-1:0]     rlen;
  logic [CNT_W-1:0]     cnt0;
  logic [CNT_W-1:0]     cnt1;
  logic                 win_full;
  logic                 win_match;
  logic [BYTE_W-1:0]    win_new   [MAX_PATTERN];
  logic [BYTE_W-1:0]    win_shift [MAX_PATTERN];
  logic [REG_W-1:0]     win_packed;
  logic [REG_W-1:0]     pend_bytes_next;
  logic [RES_CNT_W-1:0] pend_rem_next;
  logic                 pend_void_next;
  logic [CNT_W-1:0]     window_count_next;
  logic                 accept;
  logic                 move;

  // effective lengths
  always_comb begin
    if (pattern_length == '0) begin
      plen = CNT_W'(1);
    end else if (pattern_length > LEN_W'(MAX_PATTERN)) begin
      plen = CNT_W'(MAX_PATTERN);
    end else begin
      plen = CNT_W'(pattern_length);
    end
    if (replacement_length > LEN_W'(MAX_RESULTS)) begin
      rlen = LEN_W'(MAX_RESULTS);
    end else begin
      rlen = replacement_length;
    end
  end

  // insert the new word, compare against the pattern, build the result list
  always_comb begin
    cnt0 = (window_count >= plen) ? '0 : window_count;
    cnt1 = cnt0 + CNT_W'(1);
    win_full = (cnt1 == plen);
    win_match = 1'b1;
    win_packed = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      win_new[i] = (CNT_W'(i) == cnt0) ? text_in.text_byte : window_store[i];
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (CNT_W'(i) < plen && win_new[i] != pattern_bytes[i*BYTE_W +: BYTE_W]) begin
        win_match = 1'b0;
      end
      win_packed[i*BYTE_W +: BYTE_W] = win_new[i];
    end
    for (int i = 0; i < MAX_PATTERN - 1; i++) begin
      win_shift[i] = win_new[i+1];
    end
    win_shift[MAX_PATTERN-1] = win_new[MAX_PATTERN-1];

    pend_void_next = 1'b0;
    if (win_full && win_match) begin
      pend_bytes_next = replacement_bytes;
      pend_rem_next = RES_CNT_W'(rlen);
      window_count_next = '0;
    end else begin
      pend_bytes_next = win_packed;
      if (text_in.final_byte) begin
        pend_rem_next = RES_CNT_W'(cnt1);
      end else begin
        pend_rem_next = win_full ? RES_CNT_W'(1) : '0;
      end
      window_count_next = win_full ? cnt0 : cnt1;
    end
    if (text_in.final_byte) begin
      window_count_next = '0;
      if (pend_rem_next == '0) begin
        pend_rem_next = RES_CNT_W'(1);
        pend_void_next = 1'b1;
      end
    end
  end

  // handshake control
  assign move   = (pend_rem != '0) && (!out_full || text_out.ready);
  assign accept = text_in.valid && text_in.ready;
  assign text_in.ready = !rst &&
                         ((pend_rem == '0) || (pend_rem == RES_CNT_W'(1) && move));
  assign cfg.ready = !rst;

  // configuration registers and window count
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= LEN_W'(1);
      replacement_bytes  <= '0;
      replacement_length <= '0;
      window_count       <= '0;
    end else begin
      if (accept) begin
        window_count <= window_count_next;
      end
      if (cfg.valid) begin
        unique case (cfg_reg_t'(cfg.index))
          REG_PATTERN_BYTES: pattern_bytes <= cfg.data;
          REG_PATTERN_LENGTH: begin
            pattern_length <= cfg.data[LEN_W-1:0];
            window_count   <= '0;
          end
          REG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg.data;
          REG_REPLACEMENT_LENGTH: replacement_length <= cfg.data[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // window bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        window_store[i] <= (win_full && !win_match) ? win_shift[i] : win_new[i];
      end
    end
  end

  // result buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_rem <= '0;
      pend_idx <= '0;
    end else if (accept) begin
      pend_rem <= pend_rem_next;
      pend_idx <= '0;
    end else if (move) begin
      pend_rem <= pend_rem - RES_CNT_W'(1);
      pend_idx <= pend_idx + RES_IDX_W'(1);
    end
  end

  // result buffer payload
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_bytes <= pend_bytes_next;
      pend_void  <= pend_void_next;
      pend_last  <= text_in.final_byte;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (move) begin
      out_full <= 1'b1;
    end else if (text_out.ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_byte_r  <= pend_bytes[{pend_idx, 3'b000} +: BYTE_W];
      out_valid_r <= !pend_void;
      out_last_r  <= pend_last && (pend_rem == RES_CNT_W'(1));
    end
  end

  assign text_out.valid     = out_full;
  assign text_out.out_byte  = out_byte_r;
  assign text_out.out_valid = out_valid_r;
  assign text_out.out_last  = out_last_r;

  // result buffer never holds more than one word's results
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    pend_rem <= RES_CNT_W'(MAX_RESULTS))
    else $error("result buffer count out of range");

  // window never holds a full pattern between words
  a_window_short: assert property (@(posedge clk) disable iff (rst)
    window_count < plen)
    else $error("window count reached pattern length");

  // a final word always leaves at least one result behind
  a_final_emits: assert property (@(posedge clk) disable iff (rst)
    accept && text_in.final_byte |=> pend_rem != '0)
    else $error("final word produced no result");

  // an empty result word only ever closes a text
  a_void_is_last: assert property (@(posedge clk) disable iff (rst)
    out_full && !out_valid_r |-> out_last_r)
    else $error("empty result word without end mark");

  // the window is flushed after a final word
  a_final_flush: assert property (@(posedge clk) disable iff (rst)
    accept && text_in.final_byte && !cfg.valid |=> window_count == '0)
    else $error("window not flushed at end of text");

endmodule
